// ----- design/bcis_pkg.sv -----
// Package for the bounded compacting id set: operation and status codes,
// cell control struct and sizing constants. No dependencies.
package bcis_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int CAP_W           = 5;
  localparam int COUNT_W         = 5;
  localparam int ID_W            = 32;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_QUERY  = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_FULL      = 2'd2,
    ST_ABSENT    = 2'd3
  } status_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic capture;  // register the compare result for the accepted beat
    logic shift;    // remove commit: cells at or after the hit take the next entry
    logic load;     // add commit: the cell at the tail takes the key
  } cell_ctl_t;

endpackage

// ----- design/bcis_ifs.sv -----
// Channel interfaces for the bounded compacting id set: input, result and
// configuration write. Depends on bcis_pkg.
interface bcis_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        mode;
  logic signed [bcis_pkg::ID_W-1:0]  item_id;
  modport source (output valid, mode, item_id, input ready);
  modport sink   (input valid, mode, item_id, output ready);
endinterface

interface bcis_out_if;
  logic                          valid;
  logic                          ready;
  logic                          success;
  logic [1:0]                    status_code;
  logic [bcis_pkg::COUNT_W-1:0]  entry_count;
  modport source (output valid, success, status_code, entry_count, input ready);
  modport sink   (input valid, success, status_code, entry_count, output ready);
endinterface

interface bcis_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [bcis_pkg::CAP_W-1:0]  data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- design/bcis_cell.sv -----
// One storage cell of the id chain: entry word, registered compare flag,
// hit ripple and shift from the neighbor. Depends on bcis_pkg.
module bcis_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic                          clk,
  input  bcis_pkg::cell_ctl_t           ctl,
  input  logic [bcis_pkg::ID_W-1:0]     cmp_key,
  input  logic [bcis_pkg::ID_W-1:0]     load_key,
  input  logic [CNT_W-1:0]              count,
  input  logic [bcis_pkg::ID_W-1:0]     nbr_entry,
  input  logic                          hit_in,
  output logic [bcis_pkg::ID_W-1:0]     entry,
  output logic                          hit_out
);
  import bcis_pkg::*;

  logic [ID_W-1:0] entry_r;
  logic            match_r;
  logic            occupied;
  logic            at_tail;

  assign occupied = CNT_W'(IDX) < count;
  assign at_tail  = CNT_W'(IDX) == count;

  // hit somewhere at or before this cell
  assign hit_out = hit_in | match_r;
  assign entry   = entry_r;

  // compare on accept
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      match_r <= occupied && (entry_r == cmp_key);
    end
  end

  // compaction shift or append
  always_ff @(posedge clk) begin
    if (ctl.shift && hit_out) begin
      entry_r <= nbr_entry;
    end else if (ctl.load && at_tail) begin
      entry_r <= load_key;
    end
  end

endmodule

// ----- design/bounded_compacting_id_set.sv -----
// Top level of the bounded compacting id set: sequencer, count, capacity
// register, result register and the row of bcis_cell. Depends on bcis_pkg, bcis_ifs.
//
//  channel  dir  payload                               beat when
//  in_ch    in   mode, item_id                         valid & ready
//  out_ch   out  success, status_code, entry_count     valid & ready
//  cfg_ch   in   data (capacity_limit)                 valid & ready
//
// Per item: the accept edge registers the compare in every cell; at the commit
// edge the hit has rippled along the chain, and the item commits and loads the result.
// in_ch.ready is high whenever no item is in execution, also while a result waits.
// A finished item stalls in execution while out_ch holds an untaken result.
// Synchronous active-low reset empties the set and sets the capacity to 16.
module bounded_compacting_id_set #(
  parameter int MAX_ENTRIES = bcis_pkg::MAX_ENTRIES_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  bcis_in_if.sink    in_ch,
  bcis_out_if.source out_ch,
  bcis_cfg_if.sink   cfg_ch
);
  import bcis_pkg::*;

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int LW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t              state_r;
  mode_t               mode_r;
  logic [ID_W-1:0]     key_r;
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_nxt;
  logic [CAP_W-1:0]    cap_r;
  logic                out_valid_r;
  logic                success_r;
  status_t             status_r;
  logic [COUNT_W-1:0]  out_count_r;

  logic                accept;
  logic                commit;
  logic                hit;
  logic                full;
  logic                ok_nxt;
  status_t             status_nxt;
  logic [LW-1:0]       cap_ext;
  logic [LW-1:0]       lim;
  cell_ctl_t           ctl;
  logic [ID_W-1:0]     entry_w [MAX_ENTRIES];
  logic [MAX_ENTRIES:0] hit_w;

  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign commit       = (state_r == S_EXEC) && (!out_valid_r || out_ch.ready);

  // capacity saturates at the built depth
  assign cap_ext = LW'(cap_r);
  assign lim     = (cap_ext > LW'(MAX_ENTRIES)) ? LW'(MAX_ENTRIES) : cap_ext;
  assign full    = LW'(count_r) >= lim;
  assign hit     = hit_w[MAX_ENTRIES];

  // cell control
  assign ctl.capture = accept;
  assign ctl.shift   = commit && (mode_r == MODE_REMOVE) && hit;
  assign ctl.load    = commit && (mode_r == MODE_ADD) && !hit && !full;

  // outcome of the item in execution
  always_comb begin
    ok_nxt     = 1'b0;
    status_nxt = ST_OK;
    count_nxt  = count_r;
    case (mode_r)
      MODE_ADD: begin
        if (hit) begin
          status_nxt = ST_DUPLICATE;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          ok_nxt    = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      MODE_REMOVE: begin
        if (hit) begin
          ok_nxt    = 1'b1;
          count_nxt = count_r - CNT_W'(1);
        end else begin
          status_nxt = ST_ABSENT;
        end
      end
      MODE_QUERY: begin
        if (hit) begin
          ok_nxt = 1'b1;
        end else begin
          status_nxt = ST_ABSENT;
        end
      end
      MODE_CLEAR: begin
        ok_nxt    = 1'b1;
        count_nxt = '0;
      end
      default: begin
        ok_nxt = 1'b0;
      end
    endcase
  end

  // sequencer, count, capacity and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        cap_r <= cfg_ch.data;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (commit) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      if (commit) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= mode_t'(in_ch.mode);
      key_r  <= in_ch.item_id;
    end
    if (commit) begin
      success_r   <= ok_nxt;
      status_r    <= status_nxt;
      out_count_r <= COUNT_W'(count_nxt);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.success     = success_r;
  assign out_ch.status_code = status_r;
  assign out_ch.entry_count = out_count_r;

  // row of cells: hit ripples toward the tail, entries shift toward the head
  assign hit_w[0] = 1'b0;
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic [ID_W-1:0] nbr;
    if (i == MAX_ENTRIES - 1) begin : g_last
      assign nbr = entry_w[i];
    end else begin : g_mid
      assign nbr = entry_w[i+1];
    end
    bcis_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .cmp_key   (in_ch.item_id),
      .load_key  (key_r),
      .count     (count_r),
      .nbr_entry (nbr),
      .hit_in    (hit_w[i]),
      .entry     (entry_w[i]),
      .hit_out   (hit_w[i+1])
    );
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ENTRIES))
    else $error("held count beyond built depth");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_EXEC))
    else $error("accepted beat did not enter execution");

  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && (mode_r == MODE_CLEAR)) |=> (count_r == '0))
    else $error("clear left entries");

  a_remove_dec: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.shift |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("remove hit did not shrink count");

  a_load_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |-> (LW'(count_r) < LW'(MAX_ENTRIES)))
    else $error("append past the last cell");

endmodule
